// ===== sv/chained_hash_map_insert_lookup_defines.svh =====
// Assertion macros used by the hash table RTL.
// Self-contained; included by chm_datapath, the module that carries concurrent assertions.
`ifndef CHAINED_HASH_MAP_INSERT_LOOKUP_DEFINES_SVH
`define CHAINED_HASH_MAP_INSERT_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CHM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hash table property violated");
// Condition must never be seen at a clock edge outside reset.
`define CHM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("hash table forbidden condition seen");
`else
`define CHM_ASSERT(lbl, clk, rst, prop)
`define CHM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== sv/chm_pkg.sv =====
// Package for the chained hash table: sizes, operation codes and the
// command/status structs between controller and datapath. No dependencies.
package chm_pkg;

   localparam int DEF_BUCKETS = 64;
   localparam int DEF_NODES   = 256;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   // The bucket remainder is formed in steps: a reciprocal multiply for the low
   // quotient bits, then a multiply and subtract on the low key bits.
   localparam int MOD_STEPS = 2;
   localparam int MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear;     // clear one bucket head entry
      logic load;      // capture an accepted item
      logic mod_step;  // advance the bucket remainder by one step
      logic head_rd;   // read the bucket head
      logic start;     // head data is available, begin the walk
      logic node_rd;   // read the node memories
      logic cmp;       // node data is available, compare the key
      logic commit;    // update memories and load the result register
   } chm_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic head_valid;
      logic key_match;
      logic next_valid;
      logic out_free;
   } chm_stat_type;

endpackage

// ===== sv/chm_ctrl.sv =====
// Sequencer of the chained hash table: clearing pass, bucket reduction,
// chain walk and commit. Depends on chm_pkg.
module chm_ctrl
   import chm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  chm_stat_type stat,
   output chm_cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MOD   = 7'b0000100,
      S_HEAD  = 7'b0001000,
      S_START = 7'b0010000,
      S_CMP   = 7'b0100000,
      S_WRITE = 7'b1000000
   } state_type;

   localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

   state_type              state_ff, state_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;

   always_comb begin
      state_in   = state_ff;
      mod_cnt_in = mod_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               mod_cnt_in = '0;
               state_in   = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            mod_cnt_in   = mod_cnt_ff + MOD_CNT_W'(1);
            if (mod_cnt_ff == MOD_LAST) state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            if (stat.head_valid) begin
               cmd.node_rd = 1'b1;
               state_in    = S_CMP;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            // Follow the link unless this node matched or ended the chain.
            if (!stat.key_match && stat.next_valid) begin
               cmd.node_rd = 1'b1;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         mod_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mod_cnt_ff <= mod_cnt_in;
      end
   end

endmodule

// ===== sv/chm_datapath.sv =====
// Datapath of the chained hash table: item registers, bucket remainder,
// bucket head and node memories, node pool counter and result register.
// Depends on chm_pkg and chained_hash_map_insert_lookup_defines.svh.
`include "chained_hash_map_insert_lookup_defines.svh"

module chm_datapath
   import chm_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int NODES   = DEF_NODES
) (
   input  logic              clock,
   input  logic              reset,
   input  chm_cmd_type       cmd,
   output chm_stat_type      stat,
   input  logic              req_op,
   input  logic [KEY_W-1:0]  req_key,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [VAL_W-1:0]  rsp_value,
   output logic              rsp_full
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int UW = $clog2(NODES + 1);
   localparam logic [BW-1:0] BUCKET_LAST = BW'(BUCKETS - 1);
   localparam logic [UW-1:0] POOL_SIZE   = UW'(NODES);

   // Reciprocal of the bucket count, exact for every 32-bit magnitude.
   localparam int BL  = $clog2(BUCKETS);
   localparam int RSH = KEY_W + BL;
   localparam logic [KEY_W:0] RECIP =
      (KEY_W + 1)'(((64'd1 << RSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
   localparam logic [BW-1:0] BUCKET_LOW = BW'(BUCKETS);

   // Item registers.
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [KEY_W-1:0]    mag_ff, mag_in;
   logic [2*KEY_W:0]    quot_prod;
   logic [BW-1:0]       quot_ff, quot_in;
   logic [BW-1:0]       rem_ff, rem_in;
   logic                found_ff;
   logic [NW-1:0]       cur_idx_ff;

   // Memories; each head and link word carries a valid bit above the index.
   logic [NW:0]         bucket_mem [BUCKETS];
   logic [KEY_W-1:0]    node_key_mem [NODES];
   logic [VAL_W-1:0]    node_val_mem [NODES];
   logic [NW:0]         node_next_mem [NODES];

   logic [NW:0]         head_q;
   logic [KEY_W-1:0]    node_key_q;
   logic [VAL_W-1:0]    node_val_q;
   logic [NW:0]         node_next_q;

   logic [BW-1:0]       clr_ptr_ff;
   logic [UW-1:0]       used_ff;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic                rsp_full_ff;
   logic [VAL_W-1:0]    rsp_value_ff;

   logic                pool_full;
   logic                alloc;
   logic                update;
   logic [NW-1:0]       rd_addr;
   logic [NW-1:0]       new_idx;
   logic                bkt_we;
   logic [BW-1:0]       bkt_addr;
   logic [NW:0]         bkt_wdata;
   logic [VAL_W-1:0]    res_value;
   logic                res_full;

   // Magnitude of the key; the most negative key maps onto 2^31 unchanged.
   assign mag_in = req_key[KEY_W-1] ? (KEY_W'(0) - req_key) : req_key;

   // Only the low quotient bits are needed, since the remainder fits in BW bits
   // and can be formed modulo 2^BW. The first step settles the quotient, the
   // second one the remainder.
   assign quot_prod = mag_ff * RECIP;
   assign quot_in   = quot_prod[RSH +: BW];
   assign rem_in    = mag_ff[BW-1:0] - quot_ff * BUCKET_LOW;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_op);
         key_ff <= req_key;
         val_ff <= req_value;
         mag_ff <= mag_in;
      end
      if (cmd.mod_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (cmd.start) begin
         found_ff <= 1'b0;
      end else if (cmd.cmp && stat.key_match) begin
         found_ff <= 1'b1;
      end
      if (cmd.node_rd) cur_idx_ff <= rd_addr;
   end

   // Commit decisions.
   assign pool_full = (used_ff == POOL_SIZE);
   assign alloc     = cmd.commit && (op_ff == OP_INSERT) && !found_ff && !pool_full;
   assign update    = cmd.commit && (op_ff == OP_INSERT) && found_ff;
   assign new_idx   = used_ff[NW-1:0];

   // Bucket head memory: clearing pass after reset, then head insertion.
   assign bkt_we    = cmd.clear || alloc;
   assign bkt_addr  = cmd.clear ? clr_ptr_ff : rem_ff;
   assign bkt_wdata = cmd.clear ? '0 : {1'b1, new_idx};

   always_ff @(posedge clock) begin
      if (bkt_we) bucket_mem[bkt_addr] <= bkt_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.head_rd) head_q <= bucket_mem[rem_ff];
   end

   // Node memories: the walk starts at the head, then follows the links.
   assign rd_addr = cmd.start ? head_q[NW-1:0] : node_next_q[NW-1:0];

   always_ff @(posedge clock) begin
      if (alloc) begin
         node_key_mem[new_idx]  <= key_ff;
         node_next_mem[new_idx] <= head_q;
      end
      if (alloc) begin
         node_val_mem[new_idx] <= val_ff;
      end else if (update) begin
         node_val_mem[cur_idx_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.node_rd) begin
         node_key_q  <= node_key_mem[rd_addr];
         node_val_q  <= node_val_mem[rd_addr];
         node_next_q <= node_next_mem[rd_addr];
      end
   end

   // Result of the item.
   always_comb begin
      res_full  = 1'b0;
      res_value = '0;
      if (op_ff == OP_LOOKUP) begin
         if (found_ff) res_value = node_val_q;
      end else if (found_ff || !pool_full) begin
         res_value = val_ff;
      end else begin
         res_full = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ptr_ff <= (clr_ptr_ff == BUCKET_LAST) ? '0 : clr_ptr_ff + BW'(1);
         end
         if (alloc) used_ff <= used_ff + UW'(1);
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_found_ff <= found_ff;
         rsp_full_ff  <= res_full;
         rsp_value_ff <= res_value;
      end
   end

   assign stat.clear_last = (clr_ptr_ff == BUCKET_LAST);
   assign stat.head_valid = head_q[NW];
   assign stat.key_match  = (node_key_q == key_ff);
   assign stat.next_valid = node_next_q[NW];
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_full  = rsp_full_ff;
   assign rsp_value = rsp_value_ff;

   // A commit must never overwrite a result that has not been taken.
   `CHM_ASSERT(a_commit_slot_free, clock, reset, cmd.commit |-> stat.out_free)
   // The pool counter never runs past the pool.
   `CHM_ASSERT_NEVER(a_used_bound, clock, reset, used_ff > POOL_SIZE)
   // Nodes are taken one at a time and never returned.
   `CHM_ASSERT(a_used_step, clock, reset, $changed(used_ff) |-> used_ff == $past(used_ff) + UW'(1))

endmodule

// ===== sv/chained_hash_map_insert_lookup.sv =====
// Top level of the chained hash table: stream ports, controller and datapath.
// Depends on chm_pkg, chm_ctrl and chm_datapath.
//
// Usage: each request transfer on the req_ channel carries one insert-or-update
// or one lookup of a signed 32-bit key; each produces exactly one response
// transfer on the rsp_ channel, in order. The bucket is |key| mod BUCKETS and
// its chain is walked through the node memory from the newest node back.
// An insert of a key already present overwrites its value; a new key takes the
// next node of the pool and becomes the head of its chain. When all NODES nodes
// are taken, an insert of a new key returns table_full and stores nothing.
// Sequence: the remainder is formed by a reciprocal multiply, then a multiply
// and subtract; the bucket head is then read, the walk is started, any chain
// nodes are visited one after another and a commit loads the response. The next
// request is taken only after that commit. The chain walk through the single
// node memory port and a stalled receiver set the rate.
// Reset: after reset is released the block clears the bucket heads, one per
// cycle, for BUCKETS cycles, with req_tready low. When the receiver stalls, the
// finished result waits in the response register while the block accepts and
// works on the next item; it then holds at its commit until that register is free.
module chained_hash_map_insert_lookup
   import chm_pkg::*;
#(
   parameter int BUCKETS = DEF_BUCKETS,
   parameter int NODES   = DEF_NODES
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [KEY_W+VAL_W-1:0]   req_tdata,  // [31:0] lookup_key, [63:32] entry_value
   input  logic [0:0]               req_tuser,  // [0] operation
   // Response channel.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [VAL_W-1:0]         rsp_tdata,  // [31:0] result_value
   output logic [1:0]               rsp_tuser   // [0] key_found, [1] table_full
);

   chm_cmd_type  cmd;
   chm_stat_type stat;
   logic         rsp_found;
   logic         rsp_full;

   // Sequencer: the request is taken only while it waits in its idle state.
   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   chm_datapath #(
      .BUCKETS (BUCKETS),
      .NODES   (NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_op    (req_tuser[0]),
      .req_key   (req_tdata[KEY_W-1:0]),
      .req_value (req_tdata[KEY_W+VAL_W-1:KEY_W]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_found (rsp_found),
      .rsp_value (rsp_tdata),
      .rsp_full  (rsp_full)
   );

   assign rsp_tuser = {rsp_full, rsp_found};

endmodule
